// File: rtl/sce_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small CPU execute unit package
// Shared constants: opcodes, operation codes, error codes and sizes.
// ----------------------------------------------------------------------------
package sce_pkg;

    localparam int SCE_MEM_BYTES = 4096;
    localparam int SCE_REG_COUNT = 8;
    localparam int SCE_RIDX_W    = 3;

    typedef logic [31:0] t_word;

    // Opcodes in bits 2..0 of the instruction word.
    localparam logic [2:0] OP_JMP   = 3'd0;
    localparam logic [2:0] OP_LDST  = 3'd1;
    localparam logic [2:0] OP_SET   = 3'd2;
    localparam logic [2:0] OP_SETU  = 3'd3;
    localparam logic [2:0] OP_ARITH = 3'd4;
    localparam logic [2:0] OP_BIT   = 3'd5;
    localparam logic [2:0] OP_SHIFT = 3'd6;
    localparam logic [2:0] OP_NOP   = 3'd7;

    localparam logic [2:0] AR_ADD = 3'd0;
    localparam logic [2:0] AR_SUB = 3'd1;
    localparam logic [2:0] AR_MUL = 3'd2;
    localparam logic [2:0] AR_DIV = 3'd3;
    localparam logic [2:0] AR_MOD = 3'd4;

    localparam logic [1:0] BW_AND = 2'd0;
    localparam logic [1:0] BW_OR  = 2'd1;
    localparam logic [1:0] BW_XOR = 2'd2;

    localparam logic [1:0] BM_BYTE = 2'd0;
    localparam logic [1:0] BM_HALF = 2'd1;
    localparam logic [1:0] BM_WORD = 2'd2;

    localparam logic [3:0] ERR_OK        = 4'd0;
    localparam logic [3:0] ERR_BAD_REG   = 4'd1;
    localparam logic [3:0] ERR_BAD_ADDR  = 4'd2;
    localparam logic [3:0] ERR_BAD_MODE  = 4'd3;
    localparam logic [3:0] ERR_MISALIGN  = 4'd4;
    localparam logic [3:0] ERR_UNDERFLOW = 4'd5;
    localparam logic [3:0] ERR_BAD_ARITH = 4'd6;
    localparam logic [3:0] ERR_BAD_BIT   = 4'd7;
    localparam logic [3:0] ERR_HALTED    = 4'd8;

    localparam t_word SETU_KEEP_MASK = 32'h81FF_FFFF;
    localparam t_word ALL_ONES       = 32'hFFFF_FFFF;

endpackage
`default_nettype wire

// File: rtl/sce_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module sce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// File: rtl/small_cpu_execute_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Small CPU execute unit
// Executes one 32-bit instruction word per request against a register file,
// a program counter and a byte-wide data memory.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the data memory to zero, one byte per cycle;
// no request is accepted during the sweep.
// Requests are then handled one at a time. Every request, unless the unit
// is halted, reads three entries of the register file through its single
// read port, runs the checks and the ALU in the execute state, and commits
// and posts the response in the done state, where it waits while the
// previous response is still held by the receiver. The next request can be
// accepted while that response is presented. A divide or modulo by a nonzero
// divisor also runs the bit-serial divider. A store writes its bytes one by
// one, and a load reads them one by one and waits for the memory read. Once
// an instruction fails the unit is halted: later requests answer with the
// halted error and change nothing until reset.
// ----------------------------------------------------------------------------
module small_cpu_execute_unit
    import sce_pkg::*;
#(
    parameter int MEM_BYTES = SCE_MEM_BYTES,
    localparam int AW       = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_instruction_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_reg_written,
    output logic [2:0]       o_reg_index,
    output logic [31:0]      o_reg_value,
    output logic             o_jump_taken,
    output logic [31:0]      o_pc_value,
    output logic             o_mem_written,
    output logic [3:0]       o_error_code
);

    // Sequencer states.
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_MEM   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    // Where the execute cycle hands over.
    localparam logic [1:0] GO_DONE = 2'd0;
    localparam logic [1:0] GO_DIV  = 2'd1;
    localparam logic [1:0] GO_MEM  = 2'd2;

    logic [2:0]  r_state;
    t_word       r_instr;
    logic [1:0]  r_cnt;
    logic        r_rd_hit;
    t_word       r_opnd [3];
    logic [SCE_REG_COUNT-1:0] r_reg_valid;
    t_word       r_pc;
    logic        r_halted;

    // Result of the instruction in flight.
    logic        r_wr;
    logic [2:0]  r_ri;
    t_word       r_rv;
    logic        r_jt;
    t_word       r_pcn;
    logic        r_mw;
    logic [3:0]  r_err;

    // Divider.
    t_word       r_quo;
    logic [32:0] r_rem;
    t_word       r_dvs;
    logic [4:0]  r_dcnt;
    logic        r_is_mod;

    // Memory access sequencing.
    logic [AW-1:0] r_loc;
    logic [1:0]    r_last;
    logic [2:0]    r_mcnt;
    logic          r_load;
    t_word         r_sdata;
    logic [AW-1:0] r_clr;

    // Output register.
    logic        r_out_valid;

    // Register file port signals.
    logic [2:0]  rf_raddr;
    t_word       rf_rdata;
    t_word       rf_eff;
    logic        rf_we;

    // Data memory port signals.
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [7:0]    dm_wdata;
    logic [AW-1:0] dm_raddr;
    logic [7:0]    dm_rdata;

    logic        out_free;
    logic [2:0]  op;
    t_word       w;

    assign w        = r_instr;
    assign op       = r_instr[2:0];
    assign out_free = !r_out_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;

    // ------------------------------------------------------------------
    // Register file read addresses. Slot 0 is the first source (or the
    // condition register of a jump), slot 1 the jump base or the store
    // data, slot 2 the register named by the offset field.
    // ------------------------------------------------------------------
    always_comb begin
        rf_raddr = 3'd0;
        case (r_cnt)
            2'd0: begin
                case (op)
                    OP_JMP:            rf_raddr = w[7:5];
                    OP_LDST:           rf_raddr = w[12:10];
                    OP_SETU:           rf_raddr = w[5:3];
                    OP_ARITH, OP_BIT:  rf_raddr = w[12:10];
                    OP_SHIFT:          rf_raddr = w[11:9];
                    default:           rf_raddr = 3'd0;
                endcase
            end
            2'd1: begin
                case (op)
                    OP_JMP:  rf_raddr = w[10:8];
                    OP_LDST: rf_raddr = w[9:7];
                    default: rf_raddr = 3'd0;
                endcase
            end
            2'd2: begin
                case (op)
                    OP_JMP:                    rf_raddr = w[13:11];
                    OP_LDST, OP_ARITH, OP_BIT: rf_raddr = w[15:13];
                    OP_SHIFT:                  rf_raddr = w[14:12];
                    default:                   rf_raddr = 3'd0;
                endcase
            end
            default: rf_raddr = 3'd0;
        endcase
    end

    // An entry never written since reset reads as zero.
    assign rf_eff = r_rd_hit ? rf_rdata : '0;

    assign rf_we = (r_state == S_DONE) && out_free && (r_err == ERR_OK) && r_wr;

    sce_ram #(
        .WIDTH (32),
        .DEPTH (SCE_REG_COUNT)
    ) u_regfile (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (r_ri),
        .i_wdata (r_rv),
        .i_raddr (rf_raddr),
        .o_rdata (rf_rdata)
    );

    // ------------------------------------------------------------------
    // Data memory: written by the reset sweep or by stores.
    // ------------------------------------------------------------------
    always_comb begin
        dm_we    = 1'b0;
        dm_waddr = r_clr;
        dm_wdata = 8'd0;
        if (r_state == S_CLEAR) begin
            dm_we = 1'b1;
        end else if (r_state == S_MEM && !r_load) begin
            dm_we    = 1'b1;
            dm_waddr = r_loc - AW'(r_mcnt);
            dm_wdata = r_sdata[7:0];
        end
    end

    assign dm_raddr = r_loc - AW'(r_last) + AW'(r_mcnt);

    sce_ram #(
        .WIDTH (8),
        .DEPTH (MEM_BYTES)
    ) u_datamem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (dm_raddr),
        .o_rdata (dm_rdata)
    );

    // ------------------------------------------------------------------
    // Execute cycle: operand selection, checks and the combinational ALU.
    // ------------------------------------------------------------------
    t_word       a_val, c_val, b_val, x_field, x_loc, x_rv, x_pc, sh_n;
    logic        x_imm, x_badidx, b_bad, x_wr, x_jt, x_mw;
    logic [2:0]  x_ri;
    logic [3:0]  x_err;
    logic [1:0]  x_go, x_last;
    logic [63:0] rot_l, rot_r;

    assign a_val = r_opnd[0];
    assign c_val = r_opnd[1];

    always_comb begin
        x_imm    = 1'b1;
        x_field  = '0;
        x_badidx = 1'b0;
        case (op)
            OP_JMP: begin
                x_imm    = w[4];
                x_field  = {11'd0, w[31:11]};
                x_badidx = |w[31:14];
            end
            OP_LDST, OP_ARITH: begin
                x_imm    = w[6];
                x_field  = {13'd0, w[31:13]};
                x_badidx = |w[31:16];
            end
            OP_BIT: begin
                x_imm    = w[5];
                x_field  = {13'd0, w[31:13]};
                x_badidx = |w[31:16];
            end
            OP_SHIFT: begin
                x_imm    = w[4];
                x_field  = {27'd0, w[16:12]};
                x_badidx = |w[16:15];
            end
            default: begin
                x_imm = 1'b1;
            end
        endcase
    end

    assign b_val = x_imm ? x_field : r_opnd[2];
    assign b_bad = !x_imm && x_badidx;
    assign sh_n  = b_val;
    assign rot_l = {a_val, a_val} << sh_n[4:0];
    assign rot_r = {a_val, a_val} >> sh_n[4:0];

    always_comb begin
        x_err  = ERR_OK;
        x_wr   = 1'b0;
        x_ri   = 3'd0;
        x_rv   = '0;
        x_jt   = 1'b0;
        x_mw   = 1'b0;
        x_pc   = r_pc;
        x_go   = GO_DONE;
        x_loc  = a_val + b_val;
        x_last = 2'd0;
        case (op)
            OP_JMP: begin
                if (!(w[3] && a_val != '0)) begin
                    if (b_bad) begin
                        x_err = ERR_BAD_REG;
                    end else begin
                        x_pc = c_val + b_val;
                        x_jt = 1'b1;
                    end
                end
            end
            OP_LDST: begin
                case (w[5:4])
                    BM_BYTE: x_last = 2'd0;
                    BM_HALF: x_last = 2'd1;
                    default: x_last = 2'd3;
                endcase
                if (w[5:4] != BM_BYTE && w[5:4] != BM_HALF && w[5:4] != BM_WORD) begin
                    x_err = ERR_BAD_MODE;
                end else if (b_bad) begin
                    x_err = ERR_BAD_REG;
                end else if (x_loc >= 32'(MEM_BYTES)) begin
                    x_err = ERR_BAD_ADDR;
                end else if (x_loc < {30'd0, x_last}) begin
                    x_err = ERR_UNDERFLOW;
                end else if (w[3] && ((x_loc[1:0] & x_last) != x_last)) begin
                    x_err = ERR_MISALIGN;
                end else begin
                    x_go = GO_MEM;
                    if (w[3]) begin
                        x_wr = 1'b1;
                        x_ri = w[9:7];
                    end else begin
                        x_mw = 1'b1;
                    end
                end
            end
            OP_SET: begin
                x_wr = 1'b1;
                x_ri = w[6:4];
                x_rv = {(w[3] ? 7'h7F : 7'h00), w[31:7]};
            end
            OP_SETU: begin
                x_wr = 1'b1;
                x_ri = w[5:3];
                x_rv = (a_val & SETU_KEEP_MASK) | {1'b0, w[11:6], 25'd0};
            end
            OP_ARITH: begin
                x_ri = w[9:7];
                x_wr = 1'b1;
                if (b_bad) begin
                    x_err = ERR_BAD_REG;
                end else begin
                    case (w[5:3])
                        AR_ADD: x_rv = a_val + b_val;
                        AR_SUB: x_rv = a_val - b_val;
                        AR_MUL: x_rv = a_val * b_val;
                        AR_DIV: begin
                            if (b_val == '0) x_rv = ALL_ONES;
                            else             x_go = GO_DIV;
                        end
                        AR_MOD: begin
                            if (b_val == '0) x_rv = a_val;
                            else             x_go = GO_DIV;
                        end
                        default: x_err = ERR_BAD_ARITH;
                    endcase
                end
            end
            OP_BIT: begin
                x_ri = w[9:7];
                x_wr = 1'b1;
                if (b_bad) begin
                    x_err = ERR_BAD_REG;
                end else begin
                    case (w[4:3])
                        BW_AND:  x_rv = a_val & b_val;
                        BW_OR:   x_rv = a_val | b_val;
                        BW_XOR:  x_rv = a_val ^ b_val;
                        default: x_err = ERR_BAD_BIT;
                    endcase
                end
            end
            OP_SHIFT: begin
                x_ri = w[8:6];
                x_wr = 1'b1;
                if (b_bad) begin
                    x_err = ERR_BAD_REG;
                end else if (w[5]) begin
                    x_rv = w[3] ? rot_l[63:32] : rot_r[31:0];
                end else if (|sh_n[31:5]) begin
                    x_rv = '0;
                end else begin
                    x_rv = w[3] ? (a_val << sh_n[4:0]) : (a_val >> sh_n[4:0]);
                end
            end
            default: begin
                x_err = ERR_OK;
            end
        endcase
        // A failed instruction reports nothing but its error.
        if (x_err != ERR_OK) begin
            x_wr = 1'b0;
            x_ri = 3'd0;
            x_rv = '0;
            x_jt = 1'b0;
            x_mw = 1'b0;
            x_pc = r_pc;
            x_go = GO_DONE;
        end
    end

    // One restoring divide step.
    logic [32:0] dv_trial;
    logic        dv_fit;
    logic [32:0] dv_rem;
    t_word       dv_quo;

    assign dv_trial = {r_rem[31:0], r_quo[31]};
    assign dv_fit   = dv_trial >= {1'b0, r_dvs};
    assign dv_rem   = dv_fit ? (dv_trial - {1'b0, r_dvs}) : dv_trial;
    assign dv_quo   = {r_quo[30:0], dv_fit};

    // ------------------------------------------------------------------
    // Sequencer and state.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_cnt       <= 2'd0;
            r_reg_valid <= '0;
            r_pc        <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
            r_mcnt      <= 3'd0;
            r_dcnt      <= 5'd0;
        end else begin
            // A response taken while the next one is posted stays valid.
            if (r_out_valid && i_ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MEM_BYTES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_instr <= i_instruction_word;
                        r_cnt   <= 2'd0;
                        if (r_halted) begin
                            r_err   <= ERR_HALTED;
                            r_wr    <= 1'b0;
                            r_ri    <= 3'd0;
                            r_rv    <= '0;
                            r_jt    <= 1'b0;
                            r_mw    <= 1'b0;
                            r_pcn   <= r_pc;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_rd_hit <= r_reg_valid[rf_raddr];
                    r_cnt    <= r_cnt + 2'd1;
                    if (r_cnt != 2'd0) begin
                        r_opnd[r_cnt - 2'd1] <= rf_eff;
                    end
                    if (r_cnt == 2'd3) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_err    <= x_err;
                    r_wr     <= x_wr;
                    r_ri     <= x_ri;
                    r_rv     <= x_rv;
                    r_jt     <= x_jt;
                    r_mw     <= x_mw;
                    r_pcn    <= x_pc;
                    r_quo    <= a_val;
                    r_rem    <= '0;
                    r_dvs    <= b_val;
                    r_dcnt   <= 5'd0;
                    r_is_mod <= (w[5:3] == AR_MOD);
                    r_loc    <= x_loc[AW-1:0];
                    r_last   <= x_last;
                    r_mcnt   <= 3'd0;
                    r_load   <= w[3];
                    r_sdata  <= c_val;
                    case (x_go)
                        GO_DIV:  r_state <= S_DIV;
                        GO_MEM:  r_state <= S_MEM;
                        default: r_state <= S_DONE;
                    endcase
                end
                S_DIV: begin
                    r_quo  <= dv_quo;
                    r_rem  <= dv_rem;
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd31) begin
                        r_rv    <= r_is_mod ? dv_rem[31:0] : dv_quo;
                        r_state <= S_DONE;
                    end
                end
                S_MEM: begin
                    r_mcnt <= r_mcnt + 3'd1;
                    if (r_load) begin
                        // Bytes arrive in the cycle after their address, lowest
                        // address first, which is the most significant byte.
                        if (r_mcnt != 3'd0) begin
                            r_rv <= {r_rv[23:0], dm_rdata};
                        end
                        if (r_mcnt == {1'b0, r_last} + 3'd1) begin
                            r_state <= S_DONE;
                        end
                    end else begin
                        r_sdata <= r_sdata >> 8;
                        if (r_mcnt == {1'b0, r_last}) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid   <= 1'b1;
                        o_reg_written <= r_wr;
                        o_reg_index   <= r_ri;
                        o_reg_value   <= r_rv;
                        o_jump_taken  <= r_jt;
                        o_pc_value    <= r_pcn;
                        o_mem_written <= r_mw;
                        o_error_code  <= r_err;
                        if (r_err == ERR_OK) begin
                            r_pc <= r_pcn;
                            if (r_wr) begin
                                r_reg_valid[r_ri] <= 1'b1;
                            end
                        end else if (r_err != ERR_HALTED) begin
                            r_halted <= 1'b1;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// File: sim/small_cpu_execute_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small CPU execute unit checker
// Watches both channels, predicts each response from its own architectural
// state and compares all fields of every response.
// ----------------------------------------------------------------------------
module small_cpu_execute_unit_checker
    import sce_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  wire logic        i_ready_in,
    input  wire logic [31:0] i_instruction_word,
    input  wire logic        i_resp_valid,
    input  wire logic        i_ready,
    input  wire logic        i_reg_written,
    input  wire logic [2:0]  i_reg_index,
    input  wire logic [31:0] i_reg_value,
    input  wire logic        i_jump_taken,
    input  wire logic [31:0] i_pc_value,
    input  wire logic        i_mem_written,
    input  wire logic [3:0]  i_error_code,
    output int               o_fail_count,
    output int               o_outstanding
);

    typedef struct packed {
        logic        reg_written;
        logic [2:0]  reg_index;
        logic [31:0] reg_value;
        logic        jump_taken;
        logic [31:0] pc_value;
        logic        mem_written;
        logic [3:0]  error_code;
    } t_outcome;

    t_word      arch_regs [SCE_REG_COUNT];
    t_word      arch_pc;
    logic [7:0] arch_mem  [SCE_MEM_BYTES];
    logic       arch_halted;
    t_outcome   outcome_queue[$];
    int         fail_count;

    assign o_fail_count  = fail_count;
    assign o_outstanding = outcome_queue.size();

    // Resolves an operand; returns 0 when a register index is out of range.
    function automatic logic read_operand(input logic imm, input t_word field,
                                          output t_word val);
        val = field;
        if (imm) return 1'b1;
        if (field >= SCE_REG_COUNT) return 1'b0;
        val = arch_regs[field[2:0]];
        return 1'b1;
    endfunction

    function automatic t_outcome execute_word(input t_word w);
        t_outcome   o;
        logic [3:0] err;
        t_word      new_pc, a, b, r, loc, v;
        int         last;
        logic       load, imm;
        logic [4:0] n;

        o = '0;
        err = ERR_OK;
        new_pc = arch_pc;
        r = '0;
        if (arch_halted) begin
            err = ERR_HALTED;
        end else begin
            case (w[2:0])
                OP_JMP: begin
                    if (!(w[3] && arch_regs[w[7:5]] != 0)) begin
                        if (!read_operand(w[4], w >> 11, b)) err = ERR_BAD_REG;
                        else begin
                            new_pc = arch_regs[w[10:8]] + b;
                            o.jump_taken = 1'b1;
                        end
                    end
                end
                OP_LDST: begin
                    load = w[3];
                    last = (w[5:4] == BM_BYTE) ? 0 : (w[5:4] == BM_HALF) ? 1 : 3;
                    if (w[5:4] > BM_WORD) err = ERR_BAD_MODE;
                    else if (!read_operand(w[6], w >> 13, b)) err = ERR_BAD_REG;
                    else begin
                        loc = arch_regs[w[12:10]] + b;
                        if (loc >= SCE_MEM_BYTES) err = ERR_BAD_ADDR;
                        else if (loc < last) err = ERR_UNDERFLOW;
                        else if (load && (loc & last) != last) err = ERR_MISALIGN;
                        else if (load) begin
                            v = '0;
                            for (int k = last; k >= 0; k--)
                                v = (v << 8) | arch_mem[loc - k];
                            o.reg_written = 1'b1;
                            o.reg_index = w[9:7];
                            o.reg_value = v;
                        end else begin
                            v = arch_regs[w[9:7]];
                            for (int k = 0; k <= last; k++)
                                arch_mem[loc - k] = v[8*k +: 8];
                            o.mem_written = 1'b1;
                        end
                    end
                end
                OP_SET: begin
                    v = w >> 7;
                    if (w[3]) v[31:25] = '1;
                    o.reg_written = 1'b1;
                    o.reg_index = w[6:4];
                    o.reg_value = v;
                end
                OP_SETU: begin
                    o.reg_written = 1'b1;
                    o.reg_index = w[5:3];
                    o.reg_value = (arch_regs[w[5:3]] & SETU_KEEP_MASK)
                                | (t_word'(w[11:6]) << 25);
                end
                OP_ARITH, OP_BIT: begin
                    imm = (w[2:0] == OP_ARITH) ? w[6] : w[5];
                    a = arch_regs[w[12:10]];
                    if (!read_operand(imm, w >> 13, b)) err = ERR_BAD_REG;
                    else if (w[2:0] == OP_ARITH) begin
                        case (w[5:3])
                            AR_ADD:  r = a + b;
                            AR_SUB:  r = a - b;
                            AR_MUL:  r = a * b;
                            AR_DIV:  r = (b == 0) ? ALL_ONES : a / b;
                            AR_MOD:  r = (b == 0) ? a : a % b;
                            default: err = ERR_BAD_ARITH;
                        endcase
                    end else begin
                        case (w[4:3])
                            BW_AND:  r = a & b;
                            BW_OR:   r = a | b;
                            BW_XOR:  r = a ^ b;
                            default: err = ERR_BAD_BIT;
                        endcase
                    end
                    if (err == ERR_OK) begin
                        o.reg_written = 1'b1;
                        o.reg_index = w[9:7];
                        o.reg_value = r;
                    end
                end
                OP_SHIFT: begin
                    a = arch_regs[w[11:9]];
                    if (!read_operand(w[4], t_word'(w[16:12]), b)) err = ERR_BAD_REG;
                    else begin
                        n = b[4:0];
                        if (w[5]) r = (n == 0) ? a : w[3] ? ((a << n) | (a >> (32 - n)))
                                                         : ((a >> n) | (a << (32 - n)));
                        else if (b >= 32) r = '0;
                        else r = w[3] ? (a << b[4:0]) : (a >> b[4:0]);
                        o.reg_written = 1'b1;
                        o.reg_index = w[8:6];
                        o.reg_value = r;
                    end
                end
                default: ;
            endcase
        end

        if (err != ERR_OK) begin
            if (err != ERR_HALTED) arch_halted = 1'b1;
            o = '0;
            new_pc = arch_pc;
        end else begin
            if (o.reg_written) arch_regs[o.reg_index] = o.reg_value;
            arch_pc = new_pc;
        end
        o.pc_value = new_pc;
        o.error_code = err;
        return o;
    endfunction

    always @(posedge i_clk) begin
        t_outcome got, want;
        if (!i_rst_n) begin
            foreach (arch_regs[i]) arch_regs[i] = '0;
            foreach (arch_mem[i]) arch_mem[i] = '0;
            arch_pc = '0;
            arch_halted = 1'b0;
            outcome_queue.delete();
            fail_count = 0;
        end else begin
            if (i_valid && i_ready_in)
                outcome_queue.push_back(execute_word(i_instruction_word));
            if (i_resp_valid && i_ready) begin
                got = {i_reg_written, i_reg_index, i_reg_value, i_jump_taken,
                       i_pc_value, i_mem_written, i_error_code};
                if (outcome_queue.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("checker: response with no request pending: %p", got);
                end else begin
                    want = outcome_queue.pop_front();
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("checker: mismatch\n  expected %p\n  actual   %p",
                                     want, got);
                    end
                end
            end
        end
    end

endmodule

// File: sim/small_cpu_execute_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small CPU execute unit testbench
// Drives directed and random instruction streams through the execute unit,
// with bursty requests and a stalling receiver, and ends with one failing
// instruction followed by words that must report the halted error.
// ----------------------------------------------------------------------------
module small_cpu_execute_unit_test;
    import sce_pkg::*;

    localparam int RANDOM_WORDS = 650;
    localparam int CYCLE_LIMIT  = 600000;

    // The kinds of failure that can close the run; only one fits per reset.
    typedef enum int {
        FK_BAD_REG, FK_BAD_ADDR, FK_BAD_MODE, FK_MISALIGN,
        FK_UNDERFLOW, FK_BAD_ARITH, FK_BAD_BIT
    } t_fail_kind;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [31:0] i_instruction_word = '0;
    logic        i_ready = 1'b0;
    logic        o_ready, o_valid, o_reg_written, o_jump_taken, o_mem_written;
    logic [2:0]  o_reg_index;
    logic [31:0] o_reg_value, o_pc_value;
    logic [3:0]  o_error_code;
    int          fail_count, outstanding;
    int          cycle_count = 0;
    int          words_sent = 0;
    int          burst_left = 0;
    t_fail_kind  closing_fail;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    small_cpu_execute_unit u_dut (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_instruction_word,
        .o_valid, .i_ready, .o_reg_written, .o_reg_index, .o_reg_value,
        .o_jump_taken, .o_pc_value, .o_mem_written, .o_error_code
    );

    small_cpu_execute_unit_checker u_checker (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_instruction_word,
        .i_resp_valid(o_valid), .i_ready, .i_reg_written(o_reg_written),
        .i_reg_index(o_reg_index),
        .i_reg_value(o_reg_value), .i_jump_taken(o_jump_taken),
        .i_pc_value(o_pc_value), .i_mem_written(o_mem_written),
        .i_error_code(o_error_code), .o_fail_count(fail_count),
        .o_outstanding(outstanding)
    );

    // Watchdog. The limit covers the memory sweep after reset and a divide on
    // every request with the longest gaps and stalls, several times over.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("small_cpu_execute_unit_test: FAIL");
            $finish;
        end
    end

    // The receiver alternates between stretches of three stall patterns:
    // always ready, random stalls, and a rotating mask.
    always @(posedge i_clk) begin
        int   mode, left;
        logic [7:0] mask;
        if (left <= 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(50, 300);
            mask = 8'($urandom) | 8'h01;
        end
        left--;
        mask = {mask[6:0], mask[7]};
        case (mode)
            0:       i_ready <= 1'b1;
            1:       i_ready <= ($urandom_range(0, 3) != 0);
            default: i_ready <= mask[0];
        endcase
    end

    // Instruction encoders. Bits that the unit ignores are filled at random.
    function automatic t_word enc_set(logic neg, logic [2:0] dst, logic [24:0] val);
        return {val, dst, neg, OP_SET};
    endfunction

    function automatic t_word enc_setu(logic [2:0] dst, logic [5:0] val);
        return {20'($urandom), val, dst, OP_SETU};
    endfunction

    function automatic t_word enc_arith(logic [2:0] op, logic imm, logic [2:0] dst,
                                        logic [2:0] src, logic [18:0] fld);
        return {fld, src, dst, imm, op, OP_ARITH};
    endfunction

    function automatic t_word enc_bit(logic [1:0] op, logic imm, logic [2:0] dst,
                                      logic [2:0] src, logic [18:0] fld);
        return {fld, src, dst, 1'($urandom), imm, op, OP_BIT};
    endfunction

    function automatic t_word enc_shift(logic left, logic imm, logic rot, logic [2:0] dst,
                                        logic [2:0] src, logic [4:0] amt);
        return {15'($urandom), amt, src, dst, rot, imm, left, OP_SHIFT};
    endfunction

    function automatic t_word enc_ldst(logic load, logic [1:0] mode, logic imm,
                                       logic [2:0] dreg, logic [2:0] base, logic [18:0] fld);
        return {fld, base, dreg, imm, mode, load, OP_LDST};
    endfunction

    function automatic t_word enc_jmp(logic cond, logic imm, logic [2:0] creg,
                                      logic [2:0] base, logic [20:0] fld);
        return {fld, base, creg, imm, cond, OP_JMP};
    endfunction

    // Presents one request and waits for its acceptance. Requests come in
    // bursts; between bursts valid drops for a random gap, unless it is drawn as zero.
    task automatic send_word(input t_word w);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid <= 1'b1;
        i_instruction_word <= w;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // Random well-formed instruction. Register 7 is kept at zero so that
    // loads and stores can address memory through it without faulting; it
    // is only ever written with zero. A register operand always names one
    // of the eight registers.
    function automatic t_word random_word();
        logic [2:0]  dst;
        logic [1:0]  mode;
        logic        load;
        logic        imm;
        int unsigned addr;
        dst = 3'($urandom_range(0, 6));
        case ($urandom_range(0, 11))
            0: return ($urandom_range(0, 7) == 0) ? enc_set(1'b0, 3'd7, '0)
                : enc_set(1'($urandom), dst, ($urandom_range(0, 1) != 0)
                          ? 25'($urandom) : 25'($urandom_range(0, 40)));
            1: return enc_setu(dst, 6'($urandom));
            2, 3: begin
                imm = 1'($urandom);
                return enc_arith(3'($urandom_range(AR_ADD, AR_MOD)), imm, dst,
                                 3'($urandom), (!imm || $urandom_range(0, 1) != 0)
                                 ? 19'($urandom_range(0, 7)) : 19'($urandom));
            end
            4: begin
                imm = 1'($urandom);
                return enc_bit(2'($urandom_range(BW_AND, BW_XOR)), imm, dst,
                               3'($urandom), (!imm || $urandom_range(0, 1) != 0)
                               ? 19'($urandom_range(0, 7)) : 19'($urandom));
            end
            5: return ($urandom_range(0, 1) != 0)
                ? enc_shift(1'($urandom), 1'b1, 1'($urandom), dst, 3'($urandom),
                            5'($urandom))
                : enc_shift(1'($urandom), 1'b0, 1'($urandom), dst, 3'($urandom),
                            5'($urandom_range(0, 7)));
            6, 7, 8: begin
                load = 1'($urandom);
                mode = 2'($urandom_range(BM_BYTE, BM_WORD));
                if ($urandom_range(0, 9) == 0)
                    return enc_ldst(load, BM_BYTE, 1'b0, load ? dst : 3'($urandom),
                                    3'd7, 19'd7);
                addr = ($urandom_range(0, 4) == 0) ? $urandom_range(3, 4095)
                                                   : $urandom_range(3, 63);
                if (load && mode == BM_HALF) addr = addr | 1;
                if (load && mode == BM_WORD) addr = addr | 3;
                return enc_ldst(load, mode, 1'b1, load ? dst : 3'($urandom), 3'd7,
                                19'(addr));
            end
            9, 10: return ($urandom_range(0, 1) != 0)
                ? enc_jmp(1'($urandom), 1'b1, 3'($urandom), 3'($urandom), 21'($urandom))
                : enc_jmp(1'($urandom), 1'b0, 3'($urandom), 3'($urandom),
                          21'($urandom_range(0, 7)));
            default: return {29'($urandom), OP_NOP};
        endcase
    endfunction

    function automatic t_word failing_word(t_fail_kind kind);
        case (kind)
            FK_BAD_REG:   return enc_arith(AR_ADD, 1'b0, 3'd1, 3'd2,
                                           19'($urandom_range(8, 524287)));
            FK_BAD_ADDR:  return enc_ldst(1'b1, BM_BYTE, 1'b1, 3'd1, 3'd7,
                                          19'($urandom_range(4096, 524287)));
            FK_BAD_MODE:  return enc_ldst(1'($urandom), 2'd3, 1'b1, 3'd1, 3'd7, 19'd3);
            FK_MISALIGN:  return enc_ldst(1'b1, BM_HALF, 1'b1, 3'd1, 3'd7, 19'd2);
            FK_UNDERFLOW: return enc_ldst(1'b0, BM_WORD, 1'b1, 3'd1, 3'd7, 19'd1);
            FK_BAD_ARITH: return enc_arith(3'($urandom_range(5, 7)), 1'b1, 3'd1, 3'd2,
                                           19'd5);
            default:      return enc_bit(2'd3, 1'b1, 3'd1, 3'd2, 19'd5);
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: extremes, each operation and the special cases.
        send_word(enc_set(1'b1, 3'd1, '1));                  // r1 = all ones
        send_word(enc_set(1'b0, 3'd2, '0));                  // r2 = 0
        send_word(enc_set(1'b0, 3'd3, 25'd40));              // r3 = 40
        send_word(enc_setu(3'd3, 6'h3F));                    // upper bits of r3
        send_word(enc_set(1'b0, 3'd3, 25'd40));
        send_word(enc_arith(AR_ADD, 1'b1, 3'd4, 3'd1, '1));
        send_word(enc_arith(AR_SUB, 1'b0, 3'd4, 3'd2, 19'd1));
        send_word(enc_arith(AR_MUL, 1'b0, 3'd4, 3'd1, 19'd1));
        send_word(enc_arith(AR_DIV, 1'b0, 3'd4, 3'd1, 19'd2)); // divide by zero
        send_word(enc_arith(AR_MOD, 1'b0, 3'd4, 3'd1, 19'd2)); // modulo by zero
        send_word(enc_arith(AR_DIV, 1'b1, 3'd4, 3'd1, 19'd7));
        send_word(enc_bit(BW_AND, 1'b1, 3'd5, 3'd1, '1));
        send_word(enc_bit(BW_OR, 1'b0, 3'd5, 3'd3, 19'd1));
        send_word(enc_bit(BW_XOR, 1'b0, 3'd5, 3'd5, 19'd1));
        send_word(enc_shift(1'b1, 1'b0, 1'b0, 3'd6, 3'd1, 5'd3)); // shift by 40
        send_word(enc_shift(1'b0, 1'b1, 1'b1, 3'd6, 3'd3, 5'd0)); // rotate by 0
        send_word(enc_shift(1'b1, 1'b1, 1'b1, 3'd6, 3'd3, 5'd31));
        send_word(enc_shift(1'b0, 1'b1, 1'b0, 3'd6, 3'd1, 5'd31));
        send_word(enc_ldst(1'b0, BM_WORD, 1'b1, 3'd3, 3'd7, 19'd4095));
        send_word(enc_ldst(1'b0, BM_HALF, 1'b1, 3'd1, 3'd7, 19'd1));
        send_word(enc_ldst(1'b1, BM_WORD, 1'b1, 3'd4, 3'd7, 19'd4095));
        send_word(enc_ldst(1'b1, BM_HALF, 1'b1, 3'd4, 3'd7, 19'd4093));
        send_word(enc_ldst(1'b1, BM_BYTE, 1'b0, 3'd4, 3'd7, 19'd7)); // address 0
        send_word(enc_jmp(1'b1, 1'b1, 3'd1, 3'd3, '1));   // condition set: no jump
        send_word(enc_jmp(1'b1, 1'b0, 3'd2, 3'd1, 21'd3)); // condition clear: jump
        send_word({29'h1FFF_FFFF, OP_NOP});

        for (int i = 0; i < RANDOM_WORDS; i++) send_word(random_word());

        // One failure halts the unit; everything after it must be refused.
        closing_fail = t_fail_kind'($urandom_range(FK_BAD_REG, FK_BAD_BIT));
        send_word(failing_word(closing_fail));
        for (int i = 0; i < 6; i++) send_word(random_word());
        i_valid <= 1'b0;

        while (outstanding != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("sent %0d instruction words: directed, random and a closing %s fault",
                 words_sent, closing_fail.name());
        $display("followed by words issued while halted; %0d mismatches", fail_count);
        if (fail_count == 0)
            $display("small_cpu_execute_unit_test: PASS");
        else
            $display("small_cpu_execute_unit_test: FAIL");
        $finish;
    end

endmodule
